// File: rtl/core/ffha_pkg.sv
// ffha_pkg: shared types and codes of the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  localparam logic [1:0] FLAG_NONE = 2'd0;
  localparam logic [1:0] FLAG_FREE = 2'd1;
  localparam logic [1:0] FLAG_USED = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOBLOCK = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_A_SPLIT, S_H_RD, S_H_CHK,
    S_F_RD, S_F_CHK, S_F_NXRD, S_F_NXCHK, S_F_MRG, S_F_CLR, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_START, CMD_RD, CMD_A_STEP, CMD_A_TAKE, CMD_A_SPLIT,
    CMD_A_NOFIT, CMD_H_STEP, CMD_H_SET, CMD_F_STEP, CMD_F_FOUND, CMD_F_RDNX,
    CMD_F_ABSORB, CMD_F_MERGE, CMD_F_CLRCUR, CMD_F_MARK, CMD_F_NOBLK, CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free_op;
    logic at_end;
    logic fit;
    logic split;
    logic is_hint;
    logic rd_free;
    logic found;
    logic nx_end;
    logic prev_free;
  } dp_stat_t;

endpackage

// File: rtl/core/ffha_dp.sv
// ffha_dp: header memory, walk registers and arithmetic of the allocator
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_dp #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffha_pkg::dp_cmd_t cmd,
  output ffha_pkg::dp_stat_t stat,
  input  logic [31:0]       in_tdata,
  output logic [15:0]       out_tdata
);
  import ffha_pkg::*;

  localparam int IW = $clog2(HEAP_BYTES);
  localparam int AW = IW + 1;
  localparam int W  = ((AW > 13) ? AW : 13) + 2;
  localparam int EW = 2 + AW;
  localparam logic [W-1:0] HB = W'(HEADER_BYTES);
  localparam logic [W-1:0] HEAP = W'(HEAP_BYTES);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - 1 - HEADER_BYTES);

  logic [EW-1:0] mem [HEAP_BYTES];
  logic [EW-1:0] rd_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;

  logic [AW-1:0] clr_cnt_r, idx_r, hint_r, prev_r, nx_r, cur_size_r, prev_size_r;
  logic [1:0]    prev_flag_r;
  logic          have_prev_r, op_r;
  logic [12:0]   req_r;
  logic [11:0]   where_r;
  logic [1:0]    res_status_r, out_status_r;
  logic [11:0]   res_off_r, out_off_r;

  logic [1:0]    rd_flag;
  logic [AW-1:0] rd_size;
  logic [W-1:0]  step_sum, take_sum, nb, rest, kept, merged, absorbed, pay;
  logic [AW-1:0] step_nxt, take_nxt, found_nxt;
  logic          split;

  assign rd_flag = rd_q[EW-1 -: 2];
  assign rd_size = rd_q[AW-1:0];

  always_comb begin
    step_sum = W'(idx_r) + HB + W'(rd_size);
    step_nxt = (step_sum > HEAP) ? AW'(HEAP_BYTES) : step_sum[AW-1:0];
    nb       = W'(idx_r) + HB + W'(req_r);
    rest     = W'(rd_size) - HB - W'(req_r);
    split    = (W'(rd_size) > W'(req_r) + HB + HB) && (nb < HEAP);
    kept     = split ? W'(req_r) : W'(rd_size);
    take_sum = W'(idx_r) + HB + kept;
    take_nxt = (take_sum > HEAP) ? AW'(HEAP_BYTES) : take_sum[AW-1:0];
    found_nxt = step_nxt;
    absorbed = W'(cur_size_r) + HB + W'(rd_size);
    merged   = W'(prev_size_r) + HB + W'(cur_size_r);
    pay      = W'(idx_r) + HB;
  end

  always_comb begin
    stat.clr_done   = (W'(clr_cnt_r) == HEAP);
    stat.is_free_op = (op_r == OP_FREE);
    stat.at_end     = (W'(idx_r) >= HEAP);
    stat.fit        = (rd_flag == FLAG_FREE) && (W'(rd_size) >= W'(req_r));
    stat.split      = split;
    stat.is_hint    = (idx_r == hint_r);
    stat.rd_free    = (rd_flag == FLAG_FREE);
    stat.found      = (pay == W'(where_r));
    stat.nx_end     = (W'(nx_r) >= HEAP);
    stat.prev_free  = have_prev_r && (prev_flag_r == FLAG_FREE);
  end

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_data = {FLAG_NONE, AW'(0)};
    rd_en   = 1'b0;
    rd_addr = idx_r[IW-1:0];
    case (cmd)
      CMD_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r[IW-1:0];
        wr_data = (clr_cnt_r == AW'(1)) ? {FLAG_FREE, INIT_SIZE} : {FLAG_NONE, AW'(0)};
      end
      CMD_RD: rd_en = 1'b1;
      CMD_F_RDNX: begin
        rd_en   = 1'b1;
        rd_addr = nx_r[IW-1:0];
      end
      CMD_A_TAKE: begin
        wr_en   = 1'b1;
        wr_data = {FLAG_USED, kept[AW-1:0]};
      end
      CMD_A_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = nx_r[IW-1:0];
        wr_data = {FLAG_FREE, cur_size_r};
      end
      CMD_F_ABSORB: begin
        wr_en   = 1'b1;
        wr_addr = nx_r[IW-1:0];
      end
      CMD_F_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = prev_r[IW-1:0];
        wr_data = {FLAG_FREE, merged[AW-1:0]};
      end
      CMD_F_CLRCUR: wr_en = 1'b1;
      CMD_F_MARK: begin
        wr_en   = 1'b1;
        wr_data = {FLAG_FREE, cur_size_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      hint_r       <= AW'(1);
      out_status_r <= ST_OK;
      out_off_r    <= '0;
    end else begin
      case (cmd)
        CMD_CLR: clr_cnt_r <= clr_cnt_r + AW'(1);
        CMD_START: begin
          op_r         <= in_tdata[0];
          req_r        <= in_tdata[13:1];
          where_r      <= in_tdata[25:14];
          idx_r        <= (in_tdata[0] == OP_FREE) ? AW'(1) : hint_r;
          have_prev_r  <= 1'b0;
          res_status_r <= ST_OK;
          res_off_r    <= '0;
        end
        CMD_A_STEP, CMD_H_STEP: idx_r <= step_nxt;
        CMD_A_TAKE: begin
          res_off_r <= pay[11:0];
          idx_r     <= take_nxt;
          nx_r      <= nb[AW-1:0];
          cur_size_r <= rest[AW-1:0];
          if (split && (idx_r == hint_r)) begin
            hint_r <= nb[AW-1:0];
          end
        end
        CMD_A_NOFIT: res_status_r <= ST_NOFIT;
        CMD_H_SET: hint_r <= idx_r;
        CMD_F_STEP: begin
          prev_r      <= idx_r;
          prev_flag_r <= rd_flag;
          prev_size_r <= rd_size;
          have_prev_r <= 1'b1;
          idx_r       <= step_nxt;
        end
        CMD_F_FOUND: begin
          cur_size_r <= rd_size;
          nx_r       <= found_nxt;
        end
        CMD_F_ABSORB: cur_size_r <= absorbed[AW-1:0];
        CMD_F_MERGE: if (prev_r < hint_r) begin
          hint_r <= prev_r;
        end
        CMD_F_MARK: if (idx_r < hint_r) begin
          hint_r <= idx_r;
        end
        CMD_F_NOBLK: res_status_r <= ST_NOBLOCK;
        CMD_EMIT: begin
          out_status_r <= res_status_r;
          out_off_r    <= res_off_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tdata = {2'b00, out_off_r, out_status_r};

endmodule

// File: rtl/core/ffha_ctrl.sv
// ffha_ctrl: sequencing state machine of the allocator
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t  cmd
);
  import ffha_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
        else cmd = CMD_CLR;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = CMD_START;
          state_nxt = S_DISP;
        end
      end
      S_DISP: state_nxt = stat.is_free_op ? S_F_RD : S_A_RD;
      S_A_RD: begin
        if (stat.at_end) begin
          cmd       = CMD_A_NOFIT;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_RD;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat.fit) begin
          cmd = CMD_A_TAKE;
          if (stat.split) state_nxt = S_A_SPLIT;
          else if (stat.is_hint) state_nxt = S_H_RD;
          else state_nxt = S_DONE;
        end else begin
          cmd       = CMD_A_STEP;
          state_nxt = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        cmd       = CMD_A_SPLIT;
        state_nxt = S_DONE;
      end
      S_H_RD: begin
        if (stat.at_end) begin
          cmd       = CMD_H_SET;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_RD;
          state_nxt = S_H_CHK;
        end
      end
      S_H_CHK: begin
        if (stat.rd_free) begin
          cmd       = CMD_H_SET;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_H_STEP;
          state_nxt = S_H_RD;
        end
      end
      S_F_RD: begin
        if (stat.at_end) begin
          cmd       = CMD_F_NOBLK;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_RD;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.found) begin
          cmd       = CMD_F_FOUND;
          state_nxt = S_F_NXRD;
        end else begin
          cmd       = CMD_F_STEP;
          state_nxt = S_F_RD;
        end
      end
      S_F_NXRD: begin
        if (stat.nx_end) state_nxt = S_F_MRG;
        else begin
          cmd       = CMD_F_RDNX;
          state_nxt = S_F_NXCHK;
        end
      end
      S_F_NXCHK: begin
        if (stat.rd_free) cmd = CMD_F_ABSORB;
        state_nxt = S_F_MRG;
      end
      S_F_MRG: begin
        if (stat.prev_free) begin
          cmd       = CMD_F_MERGE;
          state_nxt = S_F_CLR;
        end else begin
          cmd       = CMD_F_MARK;
          state_nxt = S_DONE;
        end
      end
      S_F_CLR: begin
        cmd       = CMD_F_CLRCUR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd       = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd == CMD_EMIT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/core/first_fit_heap_allocator.sv
// first_fit_heap_allocator: first-fit allocator over an implicit header list
// each block header on the walk is read, then checked; allocate then takes or splits, free absorbs and merges
// throughput: one request at a time; next transfer accepted in the cycle after the response is loaded
// after reset a clearing pass writes every header entry before the first transfer
// depends on ffha_pkg, ffha_ctrl, ffha_dp
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // op, request_size, release_offset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, payload_offset
);
  import ffha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
